// ----- src/bpbs_pkg.sv -----
package bpbs_pkg;

	// Table geometry.
	localparam int NUM_CELLS    = 4;
	localparam int NUM_TX_BEAMS = 64;
	localparam int NUM_RX_BEAMS = 16;
	localparam int TABLE_DEPTH  = NUM_CELLS * NUM_TX_BEAMS * NUM_RX_BEAMS;
	localparam int TABLE_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths fixed by the item format.
	localparam int CELL_W = 2;
	localparam int TX_W   = 6;
	localparam int RX_W   = 4;
	localparam int SINR_W = 32;

	// Running best starts at -1.0 in Q16.16.
	localparam logic signed [SINR_W-1:0] SINR_FLOOR = -32'sd65536;

	// Item function codes.
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_FIND   = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [CELL_W-1:0]        cell_index;
		logic [TX_W-1:0]          tx_beam;
		logic [RX_W-1:0]          rx_beam;
		logic signed [SINR_W-1:0] avg_sinr;
	} in_t;

	typedef struct packed {
		logic                     best_valid;
		logic [CELL_W-1:0]        best_cell;
		logic [TX_W-1:0]          best_tx;
		logic [RX_W-1:0]          best_rx;
		logic signed [SINR_W-1:0] best_sinr;
	} out_t;

	// One table word: valid bit and stored SINR.
	typedef struct packed {
		logic                     valid;
		logic signed [SINR_W-1:0] sinr;
	} entry_t;

	// Control from the sequencer to the compare unit.
	typedef struct packed {
		logic              clr;
		logic              vld;
		logic [CELL_W-1:0] cell_id;
		logic [TX_W-1:0]   tx;
		logic [RX_W-1:0]   rx;
	} cmp_ctl_t;

	// Current winner held by the compare unit.
	typedef struct packed {
		logic                     found;
		logic [CELL_W-1:0]        cell_id;
		logic [TX_W-1:0]          tx;
		logic [RX_W-1:0]          rx;
		logic signed [SINR_W-1:0] sinr;
	} win_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DONE
	} state_t;

endpackage

// ----- src/bpbs_table.sv -----
module bpbs_table (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [bpbs_pkg::TABLE_AW-1:0] wr_addr,
	input  bpbs_pkg::entry_t              wr_data,
	input  logic                          rd_en,
	input  logic [bpbs_pkg::TABLE_AW-1:0] rd_addr,
	output bpbs_pkg::entry_t              rd_data
);

	bpbs_pkg::entry_t mem [bpbs_pkg::TABLE_DEPTH];
	bpbs_pkg::entry_t rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/bpbs_cmp.sv -----
module bpbs_cmp (
	input  logic                clk,
	input  logic                arst_n,
	input  bpbs_pkg::cmp_ctl_t  ctl,
	input  bpbs_pkg::entry_t    rd_data,
	output bpbs_pkg::win_t      win
);

	logic                                      found_q;
	logic signed [bpbs_pkg::SINR_W-1:0]        best_q;
	logic [bpbs_pkg::CELL_W-1:0]               cell_q;
	logic [bpbs_pkg::TX_W-1:0]                 tx_q;
	logic [bpbs_pkg::RX_W-1:0]                 rx_q;
	logic                                      beats;

	// Strictly greater keeps the earliest entry on a tie.
	assign beats = ctl.vld && rd_data.valid && (rd_data.sinr > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q  <= bpbs_pkg::SINR_FLOOR;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
			best_q  <= bpbs_pkg::SINR_FLOOR;
		end else if (beats) begin
			found_q <= 1'b1;
			best_q  <= rd_data.sinr;
		end
	end

	// Winner coordinates are payload and need no reset.
	always_ff @(posedge clk) begin
		if (beats) begin
			cell_q <= ctl.cell_id;
			tx_q   <= ctl.tx;
			rx_q   <= ctl.rx;
		end
	end

	assign win.found   = found_q;
	assign win.cell_id = cell_q;
	assign win.tx      = tx_q;
	assign win.rx      = rx_q;
	assign win.sinr    = best_q;

endmodule

// ----- src/beam_pair_best_sinr_table.sv -----
// Record item: one transfer per cycle while idle, no result.
// Find item: scans all TABLE_DEPTH entries through one read port and one compare unit,
// one entry per cycle; after a tail state the result is loaded once the output is free.
// The next item is accepted once the result sits in the output register.
// After arst_n the valid bits of all TABLE_DEPTH entries (4096 here) are cleared one
// entry per cycle, in_ready low; the latched best pair resets to zero and not valid.
module beam_pair_best_sinr_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpbs_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bpbs_pkg::out_t out_data
);

	localparam int AW = bpbs_pkg::TABLE_AW;

	bpbs_pkg::state_t state_q, state_nxt;

	logic [AW-1:0]                 addr_q;
	logic                          addr_last;
	logic [bpbs_pkg::CELL_W-1:0]   scan_cell_q;
	logic [bpbs_pkg::TX_W-1:0]     scan_tx_q;
	logic [bpbs_pkg::RX_W-1:0]     scan_rx_q;
	logic                          cmp_vld_s1;
	logic [bpbs_pkg::CELL_W-1:0]   cmp_cell_s1;
	logic [bpbs_pkg::TX_W-1:0]     cmp_tx_s1;
	logic [bpbs_pkg::RX_W-1:0]     cmp_rx_s1;

	logic                          in_xfer;
	logic                          is_find;
	logic                          rec_in_range;
	logic [31:0]                   rec_idx;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	bpbs_pkg::entry_t              wr_data;
	logic                          rd_en;
	bpbs_pkg::entry_t              rd_data;

	bpbs_pkg::cmp_ctl_t            cmp_ctl;
	bpbs_pkg::win_t                win;

	logic                          load_result;
	bpbs_pkg::out_t                latched_q, latched_nxt;
	bpbs_pkg::out_t                out_q;
	logic                          out_valid_q;

	assign in_xfer   = in_valid && in_ready;
	assign is_find   = (in_data.func == bpbs_pkg::FUNC_FIND);
	assign addr_last = (addr_q == AW'(bpbs_pkg::TABLE_DEPTH - 1));

	// Record address and range check.
	assign rec_in_range = (32'(in_data.cell_index) < 32'(bpbs_pkg::NUM_CELLS))
		&& (32'(in_data.tx_beam) < 32'(bpbs_pkg::NUM_TX_BEAMS))
		&& (32'(in_data.rx_beam) < 32'(bpbs_pkg::NUM_RX_BEAMS));
	assign rec_idx = (32'(in_data.cell_index) * 32'(bpbs_pkg::NUM_TX_BEAMS)
		+ 32'(in_data.tx_beam)) * 32'(bpbs_pkg::NUM_RX_BEAMS) + 32'(in_data.rx_beam);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpbs_pkg::ST_CLEAR: begin
				if (addr_last) begin
					state_nxt = bpbs_pkg::ST_IDLE;
				end
			end
			bpbs_pkg::ST_IDLE: begin
				if (in_xfer && is_find) begin
					state_nxt = bpbs_pkg::ST_SCAN;
				end
			end
			bpbs_pkg::ST_SCAN: begin
				if (addr_last) begin
					state_nxt = bpbs_pkg::ST_TAIL;
				end
			end
			bpbs_pkg::ST_TAIL: begin
				state_nxt = bpbs_pkg::ST_DONE;
			end
			bpbs_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = bpbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bpbs_pkg::ST_CLEAR;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready      = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = addr_q;
		wr_data.valid = 1'b0;
		wr_data.sinr  = in_data.avg_sinr;
		rd_en         = 1'b0;
		load_result   = 1'b0;
		case (state_q)
			bpbs_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			bpbs_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				wr_en         = in_xfer && !is_find && rec_in_range;
				wr_addr       = rec_idx[AW-1:0];
				wr_data.valid = 1'b1;
			end
			bpbs_pkg::ST_SCAN: begin
				rd_en = 1'b1;
			end
			bpbs_pkg::ST_DONE: begin
				load_result = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpbs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Address counter, shared by the clearing pass and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (state_q == bpbs_pkg::ST_CLEAR || state_q == bpbs_pkg::ST_SCAN) begin
			addr_q <= addr_last ? '0 : addr_q + AW'(1);
		end
	end

	// Scan coordinates advance with the address in cell, transmit, receive order.
	always_ff @(posedge clk) begin
		if (in_xfer && is_find) begin
			scan_cell_q <= '0;
			scan_tx_q   <= '0;
			scan_rx_q   <= '0;
		end else if (state_q == bpbs_pkg::ST_SCAN) begin
			if (scan_rx_q == bpbs_pkg::RX_W'(bpbs_pkg::NUM_RX_BEAMS - 1)) begin
				scan_rx_q <= '0;
				if (scan_tx_q == bpbs_pkg::TX_W'(bpbs_pkg::NUM_TX_BEAMS - 1)) begin
					scan_tx_q   <= '0;
					scan_cell_q <= scan_cell_q + bpbs_pkg::CELL_W'(1);
				end else begin
					scan_tx_q <= scan_tx_q + bpbs_pkg::TX_W'(1);
				end
			end else begin
				scan_rx_q <= scan_rx_q + bpbs_pkg::RX_W'(1);
			end
		end
	end

	// Align coordinates with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		cmp_cell_s1 <= scan_cell_q;
		cmp_tx_s1   <= scan_tx_q;
		cmp_rx_s1   <= scan_rx_q;
	end

	assign cmp_ctl.clr     = in_xfer && is_find;
	assign cmp_ctl.vld     = cmp_vld_s1;
	assign cmp_ctl.cell_id = cmp_cell_s1;
	assign cmp_ctl.tx      = cmp_tx_s1;
	assign cmp_ctl.rx      = cmp_rx_s1;

	bpbs_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	bpbs_cmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cmp_ctl),
		.rd_data (rd_data),
		.win     (win)
	);

	// The latch takes the winner only when the scan found one.
	always_comb begin
		latched_nxt = latched_q;
		if (win.found) begin
			latched_nxt.best_valid = 1'b1;
			latched_nxt.best_cell  = win.cell_id;
			latched_nxt.best_tx    = win.tx;
			latched_nxt.best_rx    = win.rx;
			latched_nxt.best_sinr  = win.sinr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
		end else if (load_result) begin
			latched_q <= latched_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			out_q <= latched_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/bpbs_checker.sv -----
module bpbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input bpbs_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input bpbs_pkg::out_t out_data
);

	logic       seen_valid_q;
	logic [1:0] pend_q;

	// Remember whether a latched pair was ever shown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_valid_q <= 1'b0;
		end else if (out_valid && out_data.best_valid) begin
			seen_valid_q <= 1'b1;
		end
	end

	// Finds accepted whose result has not been transferred yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q
				+ 2'((in_valid && in_ready && in_data.func == bpbs_pkg::FUNC_FIND) ? 1 : 0)
				- 2'((out_valid && out_ready) ? 1 : 0);
		end
	end

	// A held result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// No item is taken during reset.
	a_reset_not_ready: assert property (@(posedge clk) !arst_n |-> !in_ready)
		else $error("input ready during reset");

	// Once latched, the pair stays valid.
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_valid_q |-> out_data.best_valid)
		else $error("latched pair lost its valid flag");

	// A never latched result carries the reset values.
	a_unlatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.best_valid |-> out_data.best_cell == '0
		&& out_data.best_tx == '0 && out_data.best_rx == '0 && out_data.best_sinr == '0)
		else $error("unlatched result is not zero");

	// Every result belongs to an accepted find.
	a_result_has_find: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a find");

endmodule

bind beam_pair_best_sinr_table bpbs_checker u_bpbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- tb/bpbs_checker.sv -----
module bpbs_monitor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  bpbs_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  bpbs_pkg::out_t out_data,
	output int             fail_count,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the SINR table, its valid bits and the latched best pair.
	logic signed [bpbs_pkg::SINR_W-1:0] sinr_tbl [bpbs_pkg::TABLE_DEPTH];
	bit                                 written [bpbs_pkg::TABLE_DEPTH];
	bpbs_pkg::out_t                     latch;
	bpbs_pkg::out_t                     best_pairs_q [$];

	// Apply one accepted item; a find queues the latched pair it leaves behind.
	task automatic take_item(input bpbs_pkg::in_t it);
		int                                 idx;
		int                                 wc;
		int                                 wt;
		int                                 wr;
		bit                                 found;
		logic signed [bpbs_pkg::SINR_W-1:0] best;
		if (it.func == bpbs_pkg::FUNC_RECORD) begin
			if (it.cell_index < bpbs_pkg::NUM_CELLS && it.tx_beam < bpbs_pkg::NUM_TX_BEAMS
					&& it.rx_beam < bpbs_pkg::NUM_RX_BEAMS) begin
				idx = (int'(it.cell_index) * bpbs_pkg::NUM_TX_BEAMS + int'(it.tx_beam))
					* bpbs_pkg::NUM_RX_BEAMS + int'(it.rx_beam);
				sinr_tbl[idx] = it.avg_sinr;
				written[idx]  = 1'b1;
			end
		end else begin
			// Scan in cell, transmit, receive order; only a strictly greater value wins.
			best  = bpbs_pkg::SINR_FLOOR;
			found = 1'b0;
			wc    = 0;
			wt    = 0;
			wr    = 0;
			for (int c = 0; c < bpbs_pkg::NUM_CELLS; c++) begin
				for (int t = 0; t < bpbs_pkg::NUM_TX_BEAMS; t++) begin
					for (int r = 0; r < bpbs_pkg::NUM_RX_BEAMS; r++) begin
						idx = (c * bpbs_pkg::NUM_TX_BEAMS + t) * bpbs_pkg::NUM_RX_BEAMS + r;
						if (written[idx] && sinr_tbl[idx] > best) begin
							best  = sinr_tbl[idx];
							found = 1'b1;
							wc    = c;
							wt    = t;
							wr    = r;
						end
					end
				end
			end
			if (found) begin
				latch.best_valid = 1'b1;
				latch.best_cell  = bpbs_pkg::CELL_W'(wc);
				latch.best_tx    = bpbs_pkg::TX_W'(wt);
				latch.best_rx    = bpbs_pkg::RX_W'(wr);
				latch.best_sinr  = best;
			end
			best_pairs_q = {best_pairs_q, latch};
		end
	endtask

	task automatic compare(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Output transfers are checked before input transfers of the same edge.
	always @(posedge clk or negedge arst_n) begin
		bpbs_pkg::out_t want;
		if (!arst_n) begin
			for (int i = 0; i < bpbs_pkg::TABLE_DEPTH; i++) begin
				written[i]  = 1'b0;
				sinr_tbl[i] = '0;
			end
			latch = '0;
			best_pairs_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (best_pairs_q.size() == 0) begin
					$error("result transfer with no find outstanding");
					fail_count++;
				end else begin
					want = best_pairs_q.pop_front();
					compare("best_valid", 64'(want.best_valid), 64'(out_data.best_valid));
					compare("best_cell", 64'(want.best_cell), 64'(out_data.best_cell));
					compare("best_tx", 64'(want.best_tx), 64'(out_data.best_tx));
					compare("best_rx", 64'(want.best_rx), 64'(out_data.best_rx));
					compare("best_sinr", 64'(want.best_sinr), 64'(out_data.best_sinr));
				end
			end
			if (in_valid && in_ready)
				take_item(in_data);
			pending = best_pairs_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 12000;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int MIN_FINDS    = 48;
	localparam int DRAIN_CYCLES = bpbs_pkg::TABLE_DEPTH + 16;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	bpbs_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	bpbs_pkg::out_t out_data;
	int             fail_count;
	int             pending;
	int             cycles;
	int             finds_sent;
	int             burst_left;
	int             sent;
	bit             hold_go;
	bit             hold_done;

	beam_pair_best_sinr_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	bpbs_monitor u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic bpbs_pkg::in_t rec(input int cell_id, input int tx, input int rx,
			input logic signed [bpbs_pkg::SINR_W-1:0] sinr);
		bpbs_pkg::in_t it;
		it.func       = bpbs_pkg::FUNC_RECORD;
		it.cell_index = bpbs_pkg::CELL_W'(cell_id);
		it.tx_beam    = bpbs_pkg::TX_W'(tx);
		it.rx_beam    = bpbs_pkg::RX_W'(rx);
		it.avg_sinr   = sinr;
		return it;
	endfunction

	// A find carries random content in the fields it ignores.
	function automatic bpbs_pkg::in_t find_req();
		bpbs_pkg::in_t it;
		it.func       = bpbs_pkg::FUNC_FIND;
		it.cell_index = bpbs_pkg::CELL_W'($urandom_range(0, (1 << bpbs_pkg::CELL_W) - 1));
		it.tx_beam    = bpbs_pkg::TX_W'($urandom_range(0, (1 << bpbs_pkg::TX_W) - 1));
		it.rx_beam    = bpbs_pkg::RX_W'($urandom_range(0, (1 << bpbs_pkg::RX_W) - 1));
		it.avg_sinr   = $urandom;
		return it;
	endfunction

	// Hot entries get the large and tied values; cold ones stay within 4 of the floor or below it.
	function automatic logic signed [bpbs_pkg::SINR_W-1:0] pick_sinr(input bit hot);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (hot && roll < 25)
			return $urandom;
		if (hot && roll < 60)
			return $urandom_range(0, 31);
		if (roll < 80)
			return bpbs_pkg::SINR_FLOOR + $urandom_range(0, 8) - 4;
		return 32'h8000_0000 + $urandom_range(0, 32'h7FFE_FFFF);
	endfunction

	function automatic bpbs_pkg::in_t random_item();
		if ($urandom_range(0, 27) == 0)
			return find_req();
		if ($urandom_range(0, 1) == 1)
			return rec($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
				pick_sinr(1'b1));
		return rec($urandom_range(0, bpbs_pkg::NUM_CELLS - 1),
			$urandom_range(0, bpbs_pkg::NUM_TX_BEAMS - 1),
			$urandom_range(0, bpbs_pkg::NUM_RX_BEAMS - 1), pick_sinr(1'b0));
	endfunction

	// Offer one item after a random gap and return at the falling edge after its transfer.
	task automatic send(input bpbs_pkg::in_t it);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (roll < 55) begin
			gap = 0;
		end else if (roll < 85) begin
			gap = $urandom_range(1, 3);
		end else if (roll < 95) begin
			gap = $urandom_range(4, 15);
		end else begin
			gap = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		if (it.func == bpbs_pkg::FUNC_FIND)
			finds_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random ready pattern, plus one long hold-off once requested.
	initial begin
		int roll;
		int len;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 20);
				end else if (roll < 85) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 4);
				end else if (roll < 93) begin
					out_ready <= 1'b0;
					len = $urandom_range(20, 200);
				end else begin
					out_ready <= 1'b1;
					len = $urandom_range(100, 500);
				end
				repeat (len) @(negedge clk);
			end
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cycles     = 0;
		finds_sent = 0;
		burst_left = 0;
		sent       = 0;
		hold_go    = 1'b0;
		hold_done  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Never latched, then a table holding only the floor and the minimum.
		send(find_req());
		send(rec(0, 0, 0, bpbs_pkg::SINR_FLOOR));
		send(rec(bpbs_pkg::NUM_CELLS - 1, bpbs_pkg::NUM_TX_BEAMS - 1,
			bpbs_pkg::NUM_RX_BEAMS - 1, 32'sh8000_0000));
		send(find_req());
		// Just above the floor wins.
		send(rec(bpbs_pkg::NUM_CELLS - 1, bpbs_pkg::NUM_TX_BEAMS - 1,
			bpbs_pkg::NUM_RX_BEAMS - 1, bpbs_pkg::SINR_FLOOR + 1));
		send(find_req());
		// Tie at the maximum: the earlier entry in scan order wins.
		send(rec(1, 10, 5, 32'sh7FFF_FFFF));
		send(rec(2, 0, 0, 32'sh7FFF_FFFF));
		send(find_req());
		// Push the entries above the floor below it: no winner, the old pair repeats.
		send(rec(1, 10, 5, -32'sd200000));
		send(rec(2, 0, 0, -32'sd100000));
		send(rec(bpbs_pkg::NUM_CELLS - 1, bpbs_pkg::NUM_TX_BEAMS - 1,
			bpbs_pkg::NUM_RX_BEAMS - 1, -32'sd70000));
		send(find_req());
		// Small ties, then an overwrite that hands the win to the next tied entry.
		send(rec(0, 0, 0, 32'sd100));
		send(rec(0, 0, 1, 32'sd100));
		send(rec(bpbs_pkg::NUM_CELLS - 1, bpbs_pkg::NUM_TX_BEAMS - 1,
			bpbs_pkg::NUM_RX_BEAMS - 1, 32'sd100));
		send(find_req());
		send(rec(0, 0, 0, 32'sd0));
		send(find_req());

		// Long result hold-off while two finds and a run of random items keep coming.
		hold_go = 1'b1;
		send(find_req());
		send(find_req());
		repeat (10)
			send(random_item());

		// Random traffic with occasional back-to-back bursts.
		while (sent < RANDOM_ITEMS || finds_sent < MIN_FINDS) begin
			if (sent % 150 == 0)
				burst_left = 40;
			send(random_item());
			sent++;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for anything unexpected.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
